@@ hw/rtl/rcla_pkg.sv @@
// ----------------------------------------------------------------------------
// rcla_pkg
// Types, codes and helpers shared by the channel lease arbiter modules.
// ----------------------------------------------------------------------------
package rcla_pkg;

  localparam logic [2:0] CMD_LEASE  = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DENIED   = 3'd1;
  localparam logic [2:0] ST_NO_LEASE = 3'd2;
  localparam logic [2:0] ST_NOT_OWN  = 3'd3;
  localparam logic [2:0] ST_BAD_CHAN = 3'd4;

  localparam logic [1:0] CFG_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_HIST_LIM  = 2'd1;
  localparam logic [1:0] CFG_INIT_CHAN = 2'd2;

  localparam logic [7:0] PRIO_NONE = 8'hFF;
  localparam int         QDEPTH    = 4;

  typedef enum logic [2:0] {
    OP_LEASE, OP_CANCEL, OP_LOOKUP, OP_CLEAR, OP_QUERY, OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] now_time;
    logic [15:0] owner_id;
    logic [7:0]  lease_priority;
    logic [7:0]  channel;
    logic [47:0] lease_length;
    logic [31:0] cancel_key;
    logic [47:0] packet_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] result_value;
    logic        retune_valid;
    logic [7:0]  retune_channel;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } cmd_ent_t;

  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [6:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [47:0] start;
    logic [7:0]  chan;
  } hist_ent_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

endpackage

@@ hw/rtl/rcla_ram.sv @@
// ----------------------------------------------------------------------------
// rcla_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rcla_front.sv @@
// ----------------------------------------------------------------------------
// rcla_front
// Accepts command words and classifies them into operations for the queue.
// ----------------------------------------------------------------------------
module rcla_front (
  input  logic               in_push,
  input  rcla_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               in_full,
  output logic               q_we,
  output rcla_pkg::cmd_ent_t q_wdata
);
  import rcla_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_data.command)
      CMD_LEASE:  op = OP_LEASE;
      CMD_CANCEL: op = OP_CANCEL;
      CMD_LOOKUP: op = OP_LOOKUP;
      CMD_CLEAR:  op = OP_CLEAR;
      CMD_QUERY:  op = OP_QUERY;
      default:    op = OP_NOP;
    endcase
  end

  assign in_full       = q_full;
  assign q_we          = in_push && !q_full;
  assign q_wdata.op    = op;
  assign q_wdata.item  = in_data;

endmodule

@@ hw/rtl/rcla_fifo.sv @@
// ----------------------------------------------------------------------------
// rcla_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rcla_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  rcla_pkg::cmd_ent_t wdata,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output rcla_pkg::cmd_ent_t rdata
);
  import rcla_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_ent_t      ent_r [QDEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (we) begin
      ent_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (we) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(we) - (PW+1)'(pop && !empty);
    end
  end

endmodule

@@ hw/rtl/rcla_back.sv @@
// ----------------------------------------------------------------------------
// rcla_back
// Executes queued commands: lease state, dwell totals, history ring walk.
// ----------------------------------------------------------------------------
module rcla_back #(
  parameter int NUM_CHANNELS  = 14,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcla_pkg::cfg_wr_t   cfg,
  input  logic                q_empty,
  input  rcla_pkg::cmd_ent_t  q_data,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output rcla_pkg::out_item_t out_data
);
  import rcla_pkg::*;

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int NW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_DISP, S_LFIN, S_QFIN, S_HCHK, S_OUT
  } state_t;

  state_t    state_r;
  cmd_ent_t  cur_r;
  out_item_t pres_r, res_r;
  logic      res_vld_r;
  logic      init_pend_r;

  logic        en_r;
  logic [6:0]  hlim_r;
  logic [3:0]  ich_r;

  logic [7:0]  tuned_r;
  logic [47:0] since_r;
  logic [47:0] el_r;
  logic [7:0]  hprio_r;
  logic [15:0] hid_r;
  logic [47:0] expiry_r;
  logic [31:0] lcnt_r;
  logic [NW-1:0] hcnt_r;
  logic [HW-1:0] hhead_r;
  logic [HW-1:0] off_r;
  logic [NUM_CHANNELS-1:0] tvld_r;
  logic        rd_vld_r;

  // RAM ports
  logic          tot_we;
  logic [CW-1:0] tot_waddr, tot_raddr;
  logic [47:0]   tot_wdata, tot_rdata;
  logic          h_we;
  logic [HW-1:0] h_waddr, h_raddr;
  hist_ent_t     h_wdata, h_rdata;

  function automatic logic [HW-1:0] wrap(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [HW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (HW+1)'(HISTORY_DEPTH)) s = s - (HW+1)'(HISTORY_DEPTH);
    return s[HW-1:0];
  endfunction

  function automatic logic chan_ok(input logic [7:0] c);
    return (c >= 8'd1) && (c <= 8'(NUM_CHANNELS));
  endfunction

  logic [7:0]    tuned_m1, qch_m1;
  logic          tuned_ok;
  logic [NW-1:0] lim;
  logic [HW-1:0] app_slot, head_app, head_fin, off_sel;
  logic [NW-1:0] cnt_app, cnt_fin;
  logic [47:0]   tot_base;

  assign tuned_m1 = tuned_r - 8'd1;
  assign qch_m1   = cur_r.item.channel - 8'd1;
  assign tuned_ok = chan_ok(tuned_r);
  assign tot_base = rd_vld_r ? tot_rdata : 48'd0;

  always_comb begin
    if (hlim_r == 7'd0) lim = NW'(1);
    else if (int'(hlim_r) > HISTORY_DEPTH) lim = NW'(HISTORY_DEPTH);
    else lim = NW'(hlim_r);

    if (hcnt_r < NW'(HISTORY_DEPTH)) begin
      app_slot = wrap(hhead_r, hcnt_r[HW-1:0]);
      head_app = hhead_r;
      cnt_app  = hcnt_r + 1'b1;
    end else begin
      app_slot = hhead_r;
      head_app = wrap(hhead_r, HW'(1));
      cnt_app  = hcnt_r;
    end
    // A lowered limit can drop several old records at once.
    if (cnt_app > lim) begin
      head_fin = wrap(head_app, HW'(cnt_app - lim));
      cnt_fin  = lim;
    end else begin
      head_fin = head_app;
      cnt_fin  = cnt_app;
    end

    off_sel   = (state_r == S_DISP) ? HW'(hcnt_r - 1'b1) : (off_r - 1'b1);
    h_raddr   = wrap(hhead_r, off_sel);
    h_we      = (state_r == S_INIT) || (state_r == S_LFIN);
    h_waddr   = (state_r == S_INIT) ? '0 : app_slot;
    h_wdata.start = (state_r == S_INIT) ? 48'd0 : cur_r.item.now_time;
    h_wdata.chan  = (state_r == S_INIT) ? {4'd0, ich_r} : cur_r.item.channel;

    tot_raddr = (cur_r.op == OP_QUERY) ? qch_m1[CW-1:0] : tuned_m1[CW-1:0];
    tot_we    = (state_r == S_LFIN) && tuned_ok;
    tot_waddr = tuned_m1[CW-1:0];
    tot_wdata = sat_add48(tot_base, el_r);
  end

  rcla_ram #(.WIDTH(48), .DEPTH(NUM_CHANNELS)) u_tot (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(tot_raddr), .rdata(tot_rdata)
  );

  rcla_ram #(.WIDTH($bits(hist_ent_t)), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  assign q_pop     = (state_r == S_IDLE) && !init_pend_r && !q_empty;
  assign out_empty = !res_vld_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    logic [7:0]  hp;
    logic [47:0] qv;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_vld_r   <= 1'b0;
      init_pend_r <= 1'b1;
      en_r        <= 1'b1;
      hlim_r      <= 7'd64;
      ich_r       <= 4'd1;
      tuned_r     <= 8'd1;
      since_r     <= '0;
      hprio_r     <= PRIO_NONE;
      hid_r       <= '0;
      expiry_r    <= '0;
      lcnt_r      <= '0;
      hcnt_r      <= NW'(1);
      hhead_r     <= '0;
      tvld_r      <= '0;
    end else begin
      if (out_pop) res_vld_r <= 1'b0;
      rd_vld_r <= tvld_r[tot_raddr];

      if (cfg.we) begin
        unique case (cfg.index)
          CFG_ENABLE:   en_r   <= cfg.wdata[0];
          CFG_HIST_LIM: hlim_r <= cfg.wdata;
          CFG_INIT_CHAN: begin
            ich_r       <= cfg.wdata[3:0];
            tuned_r     <= {4'd0, cfg.wdata[3:0]};
            hcnt_r      <= NW'(1);
            hhead_r     <= '0;
            init_pend_r <= 1'b1;
          end
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (init_pend_r) begin
            state_r <= S_INIT;
          end else if (!q_empty) begin
            cur_r   <= q_data;
            state_r <= S_DISP;
          end
        end
        S_INIT: begin
          init_pend_r <= cfg.we && (cfg.index == CFG_INIT_CHAN);
          state_r     <= S_IDLE;
        end
        S_DISP: begin
          pres_r  <= '0;
          state_r <= S_OUT;
          el_r    <= (cur_r.item.now_time >= since_r) ? cur_r.item.now_time - since_r : '0;
          unique case (cur_r.op)
            OP_LEASE: begin
              if (en_r) begin
                hp = (cur_r.item.now_time >= expiry_r) ? PRIO_NONE : hprio_r;
                hprio_r <= hp;
                if (hp != PRIO_NONE && cur_r.item.owner_id != hid_r &&
                    cur_r.item.lease_priority > hp) begin
                  pres_r.status <= ST_DENIED;
                end else if (!chan_ok(cur_r.item.channel)) begin
                  pres_r.status <= ST_BAD_CHAN;
                end else begin
                  hid_r    <= cur_r.item.owner_id;
                  hprio_r  <= cur_r.item.lease_priority;
                  expiry_r <= sat_add48(cur_r.item.now_time, cur_r.item.lease_length);
                  lcnt_r   <= lcnt_r + 1'b1;
                  pres_r.result_value <= {16'd0, lcnt_r + 32'd1};
                  if (cur_r.item.channel != tuned_r) begin
                    pres_r.retune_valid   <= 1'b1;
                    pres_r.retune_channel <= cur_r.item.channel;
                    state_r <= S_LFIN;
                  end
                end
              end
            end
            OP_CANCEL: begin
              if (en_r) begin
                if (hprio_r == PRIO_NONE) pres_r.status <= ST_NO_LEASE;
                else if (cur_r.item.cancel_key == lcnt_r) hprio_r <= PRIO_NONE;
                else pres_r.status <= ST_NOT_OWN;
              end
            end
            OP_LOOKUP: begin
              if (hcnt_r != '0) begin
                off_r   <= HW'(hcnt_r - 1'b1);
                state_r <= S_HCHK;
              end
            end
            OP_CLEAR: begin
              tvld_r  <= '0;
              since_r <= cur_r.item.now_time;
            end
            OP_QUERY: begin
              if (!chan_ok(cur_r.item.channel)) pres_r.status <= ST_BAD_CHAN;
              else state_r <= S_QFIN;
            end
            default: ;
          endcase
        end
        S_LFIN: begin
          if (tuned_ok) tvld_r[tot_waddr] <= 1'b1;
          hhead_r <= head_fin;
          hcnt_r  <= cnt_fin;
          tuned_r <= cur_r.item.channel;
          since_r <= cur_r.item.now_time;
          state_r <= S_OUT;
        end
        S_QFIN: begin
          qv = (cur_r.item.channel == tuned_r) ? sat_add48(tot_base, el_r) : tot_base;
          pres_r.result_value <= qv;
          state_r <= S_OUT;
        end
        S_HCHK: begin
          // Newest record first; the read for the next older one is already issued.
          if (cur_r.item.packet_time > h_rdata.start) begin
            pres_r.result_value <= {40'd0, h_rdata.chan};
            state_r <= S_OUT;
          end else if (off_r == '0) begin
            state_r <= S_OUT;
          end else begin
            off_r <= off_r - 1'b1;
          end
        end
        S_OUT: begin
          if (!res_vld_r || out_pop) begin
            res_r     <= pres_r;
            res_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/radio_channel_lease_arbiter.sv @@
// ----------------------------------------------------------------------------
// radio_channel_lease_arbiter
// Lease arbiter for a radio's tuned channel with dwell totals and history.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_push / in_full     in_data   (in_item_t)
//  out_     output     out_empty / out_pop   out_data  (out_item_t)
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// Lease, cancel, clear and out-of-range queries pass through dispatch and
// output states; a retuning lease or dwell query also passes a finish state.
// A packet lookup examines history records one per cycle on the history RAM
// read port, at most HISTORY_DEPTH. After reset, and after a write of the
// initial channel, S_INIT reloads the first history record. The input queue
// holds four commands and keeps accepting while a result waits to be popped.
// ----------------------------------------------------------------------------
module radio_channel_lease_arbiter #(
  parameter int NUM_CHANNELS  = 14,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rcla_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output rcla_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_wdata
);
  import rcla_pkg::*;

  logic     q_we, q_full, q_empty, q_pop;
  cmd_ent_t q_wdata, q_rdata;
  cfg_wr_t  cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  rcla_front u_front (
    .in_push(in_push), .in_data(in_data), .q_full(q_full),
    .in_full(in_full), .q_we(q_we), .q_wdata(q_wdata)
  );

  rcla_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .we(q_we), .wdata(q_wdata), .pop(q_pop),
    .full(q_full), .empty(q_empty), .rdata(q_rdata)
  );

  rcla_back #(.NUM_CHANNELS(NUM_CHANNELS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_empty(q_empty), .q_data(q_rdata),
    .q_pop(q_pop), .out_pop(out_pop), .out_empty(out_empty), .out_data(out_data)
  );

`ifndef SYNTH
  a_retune_chan: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.retune_valid |-> out_data.retune_channel != 8'd0
      && out_data.status == ST_OK)
    else $error("retune without a valid channel or with error status");

  a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status == ST_DENIED || out_data.status == ST_NO_LEASE ||
      out_data.status == ST_NOT_OWN || out_data.status == ST_BAD_CHAN)
      |-> out_data.result_value == 48'd0 && !out_data.retune_valid)
    else $error("error result carries a value");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");
`endif

endmodule
